// ===== src/hfc_pkg.sv =====
`timescale 1ns / 1ps

package hfc_pkg;

   localparam logic [7:0]  CRC_POLY = 8'h31;
   localparam logic [7:0]  CRC_INIT = 8'hFF;
   localparam logic [14:0] T_SPAN   = 15'd17500;
   localparam logic [14:0] H_SPAN   = 15'd10000;
   localparam logic [14:0] T_OFFSET = 15'd4500;

   localparam logic QTY_TEMP  = 1'b0;
   localparam logic QTY_HUMID = 1'b1;

   typedef struct packed {
      logic        quantity;
      logic [15:0] raw_value;
      logic        crc_ok;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== src/hfc_if.sv =====
`timescale 1ns / 1ps

interface hfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface hfc_rsp_if;
   logic               valid;
   logic               ready;
   logic               quantity;
   logic        [15:0] raw_value;
   logic signed [14:0] scaled_value;
   logic               crc_ok;

   modport source (output valid, output quantity, output raw_value, output scaled_value,
                   output crc_ok, input ready);
   modport sink (input valid, input quantity, input raw_value, input scaled_value,
                 input crc_ok, output ready);
endinterface

// ===== src/hfc_front.sv =====
`timescale 1ns / 1ps

module hfc_front (
   input  logic              clock,
   input  logic              reset,
   hfc_req_if.sink           req,
   input  hfc_pkg::qstat_type q_stat,
   output logic              push,
   output hfc_pkg::rec_type  push_rec
);
   import hfc_pkg::*;

   typedef enum logic [5:0] {
      ST_T_HI  = 6'b000001,
      ST_T_LO  = 6'b000010,
      ST_T_CRC = 6'b000100,
      ST_H_HI  = 6'b001000,
      ST_H_LO  = 6'b010000,
      ST_H_CRC = 6'b100000
   } state_type;

   state_type  state_ff, state_in, cur_state;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] crc_base;
   logic       accept;
   logic       ok;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign cur_state = req.restart ? ST_T_HI : state_ff;
   assign ok        = (crc_ff == req.rx_byte);

   always_comb begin
      crc_base = crc_ff;
      if (cur_state == ST_T_HI || cur_state == ST_H_HI) begin
         crc_base = CRC_INIT;
      end
   end

   always_comb begin
      state_in = state_ff;
      crc_in   = crc_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      push     = 1'b0;
      push_rec.quantity  = QTY_TEMP;
      push_rec.raw_value = {high_ff, low_ff};
      push_rec.crc_ok    = ok;
      if (accept) begin
         unique case (cur_state)
            ST_T_LO: begin
               low_in   = req.rx_byte;
               crc_in   = crc_feed(crc_base, req.rx_byte);
               state_in = ST_T_CRC;
            end
            ST_T_CRC: begin
               push     = 1'b1;
               crc_in   = CRC_INIT;
               state_in = ok ? ST_H_HI : ST_T_HI;
            end
            ST_H_HI: begin
               high_in  = req.rx_byte;
               crc_in   = crc_feed(crc_base, req.rx_byte);
               state_in = ST_H_LO;
            end
            ST_H_LO: begin
               low_in   = req.rx_byte;
               crc_in   = crc_feed(crc_base, req.rx_byte);
               state_in = ST_H_CRC;
            end
            ST_H_CRC: begin
               push     = 1'b1;
               push_rec.quantity = QTY_HUMID;
               crc_in   = CRC_INIT;
               state_in = ST_T_HI;
            end
            default: begin
               high_in  = req.rx_byte;
               crc_in   = crc_feed(CRC_INIT, req.rx_byte);
               state_in = ST_T_LO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_T_HI;
         crc_ff   <= CRC_INIT;
         high_ff  <= '0;
         low_ff   <= '0;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

endmodule

// ===== src/hfc_queue.sv =====
`timescale 1ns / 1ps

module hfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hfc_pkg::rec_type   push_rec,
   input  logic               pop,
   output hfc_pkg::rec_type   pop_rec,
   output hfc_pkg::qstat_type q_stat
);
   import hfc_pkg::*;

   rec_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_rec      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/hfc_back.sv =====
`timescale 1ns / 1ps

module hfc_back (
   input  logic               clock,
   input  logic               reset,
   input  hfc_pkg::qstat_type q_stat,
   input  hfc_pkg::rec_type   pop_rec,
   output logic               pop,
   hfc_rsp_if.source          rsp
);
   import hfc_pkg::*;

   logic               valid_ff, valid_in;
   logic               qty_ff, qty_in;
   logic        [15:0] raw_ff, raw_in;
   logic signed [14:0] scaled_ff, scaled_in;
   logic               ok_ff, ok_in;
   logic        [14:0] span;
   logic        [30:0] product;
   logic        [14:0] frac;

   assign pop     = !q_stat.empty && (!valid_ff || rsp.ready);
   assign span    = (pop_rec.quantity == QTY_HUMID) ? H_SPAN : T_SPAN;
   assign product = {15'd0, pop_rec.raw_value} * {16'd0, span};
   assign frac    = product[30:16];

   always_comb begin
      valid_in  = valid_ff && !rsp.ready;
      qty_in    = qty_ff;
      raw_in    = raw_ff;
      scaled_in = scaled_ff;
      ok_in     = ok_ff;
      if (pop) begin
         valid_in  = 1'b1;
         qty_in    = pop_rec.quantity;
         raw_in    = pop_rec.raw_value;
         ok_in     = pop_rec.crc_ok;
         scaled_in = (pop_rec.quantity == QTY_HUMID) ? signed'(frac)
                                                     : signed'(frac - T_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qty_ff    <= qty_in;
      raw_ff    <= raw_in;
      scaled_ff <= scaled_in;
      ok_ff     <= ok_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.quantity     = qty_ff;
   assign rsp.raw_value    = raw_ff;
   assign rsp.scaled_value = scaled_ff;
   assign rsp.crc_ok       = ok_ff;

endmodule

// ===== src/humidity_temp_frame_checker_unit.sv =====
`timescale 1ns / 1ps

// Takes one received sensor byte per cycle while req ready is high (temperature
// high, low, CRC, then humidity high, low, CRC; restart forces the byte to be a
// temperature high byte) and emits one item per CRC byte with the raw word, the
// scaled value in hundredths and crc_ok. A bad temperature CRC restarts the
// sequence. The CRC is unrolled, so the front end takes a byte every cycle while
// ready is high; results enter a two-entry queue and a single constant multiply
// fills the output register, which an item reaches via the queue. req ready falls
// only while two results sit in the queue behind a stalled output register.

module humidity_temp_frame_checker_unit (
   input logic       clock,
   input logic       reset,
   hfc_req_if.sink   req_if,
   hfc_rsp_if.source rsp_if
);
   import hfc_pkg::*;

   qstat_type q_stat;
   rec_type   push_rec;
   rec_type   pop_rec;
   logic      push;
   logic      pop;

   hfc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec)
   );

   hfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_stat   (q_stat)
   );

   hfc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .pop_rec (pop_rec),
      .pop     (pop),
      .rsp     (rsp_if)
   );

endmodule

// ===== src/hfc_checker.sv =====
`timescale 1ns / 1ps

module hfc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_quantity,
   input logic        [15:0] rsp_raw_value,
   input logic signed [14:0] rsp_scaled_value,
   input logic               rsp_crc_ok
);
   import hfc_pkg::*;

   logic [30:0] exp_product;
   logic [14:0] exp_frac;
   logic [14:0] exp_scaled;

   assign exp_product = {15'd0, rsp_raw_value} *
                        {16'd0, (rsp_quantity == QTY_HUMID) ? H_SPAN : T_SPAN};
   assign exp_frac    = exp_product[30:16];
   assign exp_scaled  = (rsp_quantity == QTY_HUMID) ? exp_frac : exp_frac - T_OFFSET;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quantity) &&
         $stable(rsp_raw_value) && $stable(rsp_scaled_value) && $stable(rsp_crc_ok))
      else $error("stalled result changed");

   a_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scaled_value == signed'(exp_scaled))
      else $error("scaled value does not match raw word");

   a_humid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quantity == QTY_HUMID |->
         rsp_scaled_value >= 15'sd0 && rsp_scaled_value <= 15'sd9999)
      else $error("humidity out of range");

endmodule

bind humidity_temp_frame_checker_unit hfc_checker u_hfc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_quantity     (rsp_if.quantity),
   .rsp_raw_value    (rsp_if.raw_value),
   .rsp_scaled_value (rsp_if.scaled_value),
   .rsp_crc_ok       (rsp_if.crc_ok)
);
